/* hw/rtl/sbus_channel_decoder_top_macros.svh */
// ----------------------------------------------------------------------------
// SBUS channel decoder assertion macros
// Shared concurrent assertion forms for the decoder modules.
// ----------------------------------------------------------------------------
`ifndef SBUS_CHANNEL_DECODER_TOP_MACROS_SVH
`define SBUS_CHANNEL_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbus decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbus decoder check failed");

`endif

/* hw/rtl/scd_pkg.sv */
// ----------------------------------------------------------------------------
// SBUS channel decoder package
// Constants, register codes and shared types of the decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int FRAME_LEN    = 25;
  localparam int STORE_DEPTH  = FRAME_LEN - 1;
  localparam int DATA_BYTES   = 22;
  localparam int CHAN_W       = 11;
  localparam int CHAN_BITS    = NUM_CHANNELS * CHAN_W;
  localparam int POS_W        = 5;
  localparam int IDX_W        = 4;
  localparam int VAL_W        = 12;
  localparam int SUM_W        = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] IDLE_POS  = POS_W'(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_CHAN = IDX_W'(NUM_CHANNELS - 1);

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE    = 8'h00;

  localparam logic [VAL_W-1:0] OFFSET_RST     = 12'd0;
  localparam logic [VAL_W-1:0] CLAMP_LOW_RST  = 12'd1000;
  localparam logic [VAL_W-1:0] CLAMP_HIGH_RST = 12'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_OFFSET = 2'd0,
    REG_CLAMP_LOW      = 2'd1,
    REG_CLAMP_HIGH     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [VAL_W-1:0] channel_offset;
    logic [VAL_W-1:0] clamp_low;
    logic [VAL_W-1:0] clamp_high;
  } trim_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 ok;
    logic [CHAN_BITS-1:0] data;
  } frame_t;

endpackage

/* hw/rtl/scd_frame_collect.sv */
// ----------------------------------------------------------------------------
// SBUS frame collector
// Stores received bytes by position and hands a finished frame to the drain.
// ----------------------------------------------------------------------------
module scd_frame_collect import scd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_start,
  input  logic       drain_busy,
  output frame_t     frame_o
);

  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       pos_nxt;
  logic [7:0]             store_r [STORE_DEPTH];
  logic                   accept;
  logic                   wr_en;
  logic [POS_W-1:0]       wr_idx;
  logic [DATA_BYTES*8-1:0] bytes_v;

  assign in_ready = !(drain_busy && (pos_r == LAST_POS));
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos_nxt = pos_r;
    wr_en   = 1'b0;
    wr_idx  = pos_r;
    if (accept) begin
      if (in_frame_start) begin
        pos_nxt = POS_W'(1);
        wr_en   = 1'b1;
        wr_idx  = '0;
      end else if (pos_r < IDLE_POS) begin
        pos_nxt = pos_r + POS_W'(1);
        wr_en   = (pos_r < LAST_POS);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      bytes_v[i*8 +: 8] = store_r[i+1];
    end
  end

  always_comb begin
    frame_o.valid = accept && !in_frame_start && (pos_r == LAST_POS);
    frame_o.ok    = (store_r[0] == HEADER_BYTE) && (in_rx_byte == END_BYTE);
    frame_o.data  = bytes_v[CHAN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= IDLE_POS;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= in_rx_byte;
    end
  end

endmodule

/* hw/rtl/scd_channel_drain.sv */
// ----------------------------------------------------------------------------
// SBUS channel drain
// Unpacks one channel per cycle unless stalled; trims, clamps and registers it.
// ----------------------------------------------------------------------------
`include "sbus_channel_decoder_top_macros.svh"

module scd_channel_drain import scd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  frame_t           frame_i,
  input  trim_cfg_t        cfg_i,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_channel_index,
  output logic [VAL_W-1:0] out_channel_value,
  output logic             out_frame_ok,
  output logic             out_last_channel
);

  logic [CHAN_BITS-1:0] buf_r;
  logic                 ok_r;
  logic                 busy_r;
  logic [IDX_W-1:0]     cnt_r;
  logic                 out_valid_r;
  logic [IDX_W-1:0]     idx_r;
  logic [VAL_W-1:0]     val_r;
  logic                 fok_r;
  logic                 last_r;
  logic                 advance;
  logic [CHAN_W-1:0]    raw;
  logic [SUM_W-1:0]     sum;
  logic [VAL_W-1:0]     val_nxt;

  assign advance = busy_r && (!out_valid_r || out_ready);

  always_comb begin
    raw = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (cnt_r == IDX_W'(k)) begin
        raw = buf_r[k*CHAN_W +: CHAN_W];
      end
    end
    if (!ok_r) begin
      raw = '0;
    end
  end

  always_comb begin
    sum = {{(SUM_W-CHAN_W){1'b0}}, raw} +
          {{(SUM_W-VAL_W){cfg_i.channel_offset[VAL_W-1]}}, cfg_i.channel_offset};
    if (sum < {{(SUM_W-VAL_W){1'b0}}, cfg_i.clamp_low}) begin
      val_nxt = cfg_i.clamp_low;
    end else if (sum > {{(SUM_W-VAL_W){1'b0}}, cfg_i.clamp_high}) begin
      val_nxt = cfg_i.clamp_high;
    end else begin
      val_nxt = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (frame_i.valid) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (advance) begin
        cnt_r <= cnt_r + IDX_W'(1);
        if (cnt_r == LAST_CHAN) begin
          busy_r <= 1'b0;
        end
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_i.valid) begin
      buf_r <= frame_i.data;
      ok_r  <= frame_i.ok;
    end
    if (advance) begin
      idx_r  <= cnt_r;
      val_r  <= val_nxt;
      fok_r  <= ok_r;
      last_r <= (cnt_r == LAST_CHAN);
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_channel_index = idx_r;
  assign out_channel_value = val_r;
  assign out_frame_ok      = fok_r;
  assign out_last_channel  = last_r;

  `SCD_ASSERT_NOW(a_load_when_idle, clk, rst_n, frame_i.valid, !busy_r)
  `SCD_ASSERT_NEXT(a_burst_ends, clk, rst_n, advance && (cnt_r == LAST_CHAN), !busy_r && last_r)
  `SCD_ASSERT_NEXT(a_advance_shows, clk, rst_n, advance, out_valid_r && (idx_r == $past(cnt_r)))

endmodule

/* hw/rtl/sbus_channel_decoder_top.sv */
// Byte 24 completes a frame and hands it to the drain, which registers its 16 channel results.
// Throughput: one byte per cycle while in_ready; 16 results, one per cycle while out_ready.
// Byte 24 of a frame is held off while the previous frame's results are still in the drain.
// Reset is synchronous, active low; it clears the byte position to waiting-for-start,
// empties the drain and output register, and restores offset 0 and limits 1000 and 2000.
// ----------------------------------------------------------------------------
// SBUS channel decoder top level
// Configuration registers, frame collector and channel drain.
// ----------------------------------------------------------------------------
module sbus_channel_decoder_top import scd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_frame_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_channel_index,
  output logic [VAL_W-1:0]     out_channel_value,
  output logic                 out_frame_ok,
  output logic                 out_last_channel,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  trim_cfg_t cfg_r;
  frame_t    frame;
  logic      drain_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_offset <= OFFSET_RST;
      cfg_r.clamp_low      <= CLAMP_LOW_RST;
      cfg_r.clamp_high     <= CLAMP_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHANNEL_OFFSET: cfg_r.channel_offset <= cfg_data;
        REG_CLAMP_LOW:      cfg_r.clamp_low      <= cfg_data;
        REG_CLAMP_HIGH:     cfg_r.clamp_high     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  scd_frame_collect u_collect (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .drain_busy     (drain_busy),
    .frame_o        (frame)
  );

  scd_channel_drain u_drain (
    .clk               (clk),
    .rst_n             (rst_n),
    .frame_i           (frame),
    .cfg_i             (cfg_r),
    .busy              (drain_busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_frame_ok      (out_frame_ok),
    .out_last_channel  (out_last_channel)
  );

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// SBUS channel decoder testbench
// Feeds whole, broken and restarted 25-byte frames through the byte channel
// under several trim and clamp settings and varied handshake pressure. A
// frame decoder kept alongside the block predicts every channel transfer,
// and each channel transfer is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
  import scd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASE_BYTES   = 20;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             ok;
    logic             last;
  } channel_word_t;

  typedef struct {
    logic [7:0]       head;
    logic [7:0]       tail;
    int               fill;
    int               lead;
    int               restart_at;
    int               trail;
    logic             fixed;
    logic [VAL_W-1:0] value;
    logic             ok;
  } frame_case_t;

  typedef struct {
    logic [VAL_W-1:0] offset;
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] high;
    logic             pick_random;
    int               send_idle;
    int               recv_stall;
  } trim_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = '0;
  logic                 in_frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     out_channel_index;
  logic [VAL_W-1:0]     out_channel_value;
  logic                 out_frame_ok;
  logic                 out_last_channel;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  logic [7:0]       frame_buf [FRAME_LEN];
  logic [POS_W-1:0] frame_pos = IDLE_POS;
  logic [VAL_W-1:0] trim_offset = OFFSET_RST;
  logic [VAL_W-1:0] lim_low = CLAMP_LOW_RST;
  logic [VAL_W-1:0] lim_high = CLAMP_HIGH_RST;
  channel_word_t    pending_channels [$];

  logic             row_fixed = 1'b0;
  logic [VAL_W-1:0] row_value = '0;
  logic             row_ok = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int channels_checked = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  frame_case_t frame_cases [8] = '{
    '{8'h0F, 8'h00, 8'h00, 0, 0, 0, 1'b1, 12'd1000, 1'b1},
    '{8'h0F, 8'h00, 8'hFF, 0, 0, 0, 1'b1, 12'd2000, 1'b1},
    '{8'hF0, 8'h00, 8'hFF, 0, 0, 0, 1'b1, 12'd1000, 1'b0},
    '{8'h0F, 8'hFF, 8'h00, 0, 0, 0, 1'b1, 12'd1000, 1'b0},
    '{8'h0F, 8'h00, 8'hA5, 3, 0, 2, 1'b0, 12'd0, 1'b0},
    '{8'h0F, 8'h00, 8'h5A, 0, 9, 0, 1'b0, 12'd0, 1'b0},
    '{8'h0F, 8'h00, -1, 0, 0, 0, 1'b0, 12'd0, 1'b0},
    '{8'h00, 8'h00, 8'hFF, 0, 0, 0, 1'b1, 12'd1000, 1'b0}
  };

  trim_phase_t trim_phases [6] = '{
    '{12'h000, 12'd0, 12'd4095, 1'b0, 0, 0},
    '{12'h7FF, 12'd0, 12'd4095, 1'b0, 58, 0},
    '{12'h800, 12'd0, 12'd4095, 1'b0, 0, 58},
    '{12'hF9C, 12'd500, 12'd1800, 1'b0, 35, 35},
    '{12'h000, 12'd3000, 12'd1000, 1'b0, 0, 0},
    '{12'h000, 12'd0, 12'd0, 1'b1, 35, 35}
  };

  sbus_channel_decoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_frame_ok      (out_frame_ok),
    .out_last_channel  (out_last_channel),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] v);
    case (cfg_reg_t'(idx))
      REG_CHANNEL_OFFSET: trim_offset = v;
      REG_CLAMP_LOW:      lim_low = v;
      REG_CLAMP_HIGH:     lim_high = v;
      default: ;
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [CHAN_BITS-1:0] bits;
    logic [CHAN_W-1:0]    raw;
    logic [SUM_W-1:0]     sum;
    logic                 ok;
    channel_word_t        word;
    int                   i;
    int                   k;
    if (start) begin
      frame_pos = '0;
    end
    if (frame_pos >= IDLE_POS) begin
      return;
    end
    frame_buf[frame_pos] = b;
    if (frame_pos != LAST_POS) begin
      frame_pos++;
      return;
    end
    frame_pos = IDLE_POS;
    ok = (frame_buf[0] == HEADER_BYTE) && (frame_buf[LAST_POS] == END_BYTE);
    for (i = 0; i < DATA_BYTES; i++) begin
      bits[i*8 +: 8] = frame_buf[i+1];
    end
    for (k = 0; k < NUM_CHANNELS; k++) begin
      raw = ok ? bits[k*CHAN_W +: CHAN_W] : '0;
      sum = SUM_W'(raw) + {{(SUM_W-VAL_W){trim_offset[VAL_W-1]}}, trim_offset};
      if (sum < SUM_W'(lim_low)) begin
        word.value = lim_low;
      end else if (sum > SUM_W'(lim_high)) begin
        word.value = lim_high;
      end else begin
        word.value = sum[VAL_W-1:0];
      end
      word.ok = ok;
      if (row_fixed) begin
        word.value = row_value;
        word.ok = row_ok;
      end
      word.index = IDX_W'(k);
      word.last = (k == NUM_CHANNELS - 1);
      pending_channels.push_back(word);
    end
  endtask

  task automatic check_channel();
    channel_word_t want;
    if (pending_channels.size() == 0) begin
      flag_error($sformatf("unexpected channel transfer, index %0d", out_channel_index));
      return;
    end
    want = pending_channels.pop_front();
    channels_checked++;
    if (out_channel_index !== want.index) begin
      flag_error($sformatf("channel index %0d, predicted %0d", out_channel_index, want.index));
    end
    if (out_channel_value !== want.value) begin
      flag_error($sformatf("channel %0d value %0d, predicted %0d",
                           want.index, out_channel_value, want.value));
    end
    if (out_frame_ok !== want.ok) begin
      flag_error($sformatf("channel %0d frame_ok %b, predicted %b",
                           want.index, out_frame_ok, want.ok));
    end
    if (out_last_channel !== want.last) begin
      flag_error($sformatf("channel %0d last_channel %b, predicted %b",
                           want.index, out_last_channel, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        decode_byte(in_rx_byte, in_frame_start);
      end
      if (out_valid && out_ready) begin
        check_channel();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout with %0d channel transfers outstanding.", pending_channels.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_frame_start <= start;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  function automatic logic [7:0] data_byte(input int fill);
    if (fill >= 0) begin
      return fill[7:0];
    end
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] head, input logic [7:0] tail, input int fill,
                            input int lead, input int restart_at, input int trail);
    int p;
    repeat (lead) push_byte(8'($urandom_range(255)), 1'b0);
    if (restart_at > 0) begin
      push_byte(head, 1'b1);
      for (p = 1; p < restart_at; p++) begin
        push_byte(data_byte(fill), 1'b0);
      end
    end
    push_byte(head, 1'b1);
    for (p = 1; p < LAST_POS; p++) begin
      push_byte(data_byte(fill), 1'b0);
    end
    push_byte(tail, 1'b0);
    repeat (trail) push_byte(8'($urandom_range(255)), 1'b0);
    frames_sent++;
  endtask

  task automatic random_item();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_frame(HEADER_BYTE, END_BYTE, -1, $urandom_range(2), 0, $urandom_range(2));
    end else if (pick < 78) begin
      send_frame(8'($urandom_range(255)), END_BYTE, -1, 0, 0, 0);
    end else if (pick < 85) begin
      send_frame(HEADER_BYTE, 8'($urandom_range(1, 255)), -1, 0, 0, 0);
    end else if (pick < 93) begin
      send_frame(HEADER_BYTE, END_BYTE, -1, 0, $urandom_range(1, LAST_POS), 0);
    end else begin
      n = $urandom_range(1, 30);
      repeat (n) push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    end
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [VAL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_channels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [VAL_W-1:0] offset;
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] high;
    int               stop_at;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (frame_cases[i]) begin
      row_fixed <= frame_cases[i].fixed;
      row_value <= frame_cases[i].value;
      row_ok <= frame_cases[i].ok;
      send_frame(frame_cases[i].head, frame_cases[i].tail, frame_cases[i].fill,
                 frame_cases[i].lead, frame_cases[i].restart_at, frame_cases[i].trail);
    end
    row_fixed <= 1'b0;

    foreach (trim_phases[n]) begin
      wait_drained();
      offset = trim_phases[n].offset;
      low = trim_phases[n].low;
      high = trim_phases[n].high;
      if (trim_phases[n].pick_random) begin
        offset = VAL_W'($urandom_range(4095));
        low = VAL_W'($urandom_range(1500));
        high = VAL_W'($urandom_range(2000, 4095));
      end
      write_reg(REG_CHANNEL_OFFSET, offset);
      write_reg(REG_CLAMP_LOW, low);
      write_reg(REG_CLAMP_HIGH, high);
      settings_used++;
      send_idle_pct = trim_phases[n].send_idle;
      recv_stall_pct = trim_phases[n].recv_stall;
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
        random_item();
      end
    end
    wait_drained();

    $display("Sent %0d bytes in %0d framed sequences plus noise bursts.", bytes_sent,
             frames_sent);
    $display("Checked %0d channel transfers under the reset and %0d written trim settings.",
             channels_checked, settings_used);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/scd_pkg.sv
hw/rtl/scd_frame_collect.sv
hw/rtl/scd_channel_drain.sv
hw/rtl/sbus_channel_decoder_top.sv
dv/testbench.sv
